// ===== rtl/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// asgr_pkg: shared types and constants of the sgr colour parser
// codepoint constants, palette tables, queue sizing and register indexes
// ----------------------------------------------------------------------------
package asgr_pkg;

   localparam int CP_W        = 21;
   localparam int RGB_W       = 24;
   localparam int ALPHA_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] CP_ESC      = 21'h00001B;
   localparam logic [CP_W-1:0] CP_LBRACKET = 21'h00005B;
   localparam logic [CP_W-1:0] CP_M        = 21'h00006D;
   localparam logic [CP_W-1:0] CP_SEMI     = 21'h00003B;
   localparam logic [CP_W-1:0] CP_ZERO     = 21'h000030;
   localparam logic [CP_W-1:0] CP_NINE     = 21'h000039;

   localparam logic [7:0] SGR_RESET    = 8'd0;
   localparam logic [7:0] SGR_BOLD     = 8'd1;
   localparam logic [7:0] SGR_NOT_BOLD = 8'd22;
   localparam logic [7:0] SGR_FG_FIRST = 8'd30;
   localparam logic [7:0] SGR_FG_LAST  = 8'd37;

   localparam logic [2:0] PAL_IDX_RESET = 3'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_RGB      = 2'd0,
      CSR_TOP_ALPHA    = 2'd1,
      CSR_BOTTOM_RGB   = 2'd2,
      CSR_BOTTOM_ALPHA = 2'd3
   } asgr_csr_type;

   // colour in effect for one character
   typedef struct packed {
      logic       is_default;
      logic       bold_table;
      logic [2:0] index;
   } asgr_colour_type;

   // one queued character waiting for colour lookup
   typedef struct packed {
      logic [CP_W-1:0] codepoint;
      asgr_colour_type colour;
   } asgr_entry_type;

   // queue status seen by the producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } asgr_qstat_type;

   function automatic logic [RGB_W-1:0] palette_rgb(input logic bold, input logic [2:0] idx);
      logic [RGB_W-1:0] rgb;
      rgb = '0;
      if (bold) begin
         case (idx)
            3'd0: rgb = 24'h808080;
            3'd1: rgb = 24'hFF0000;
            3'd2: rgb = 24'h00FF00;
            3'd3: rgb = 24'hFFFF00;
            3'd4: rgb = 24'h5C5CFF;
            3'd5: rgb = 24'hFF00FF;
            3'd6: rgb = 24'h00FFFF;
            default: rgb = 24'hFFFFFF;
         endcase
      end else begin
         case (idx)
            3'd0: rgb = 24'h000000;
            3'd1: rgb = 24'hCC0000;
            3'd2: rgb = 24'h00CC00;
            3'd3: rgb = 24'hCCCC00;
            3'd4: rgb = 24'h0000ED;
            3'd5: rgb = 24'hCC00CC;
            3'd6: rgb = 24'h00CCCC;
            default: rgb = 24'hBFBFBF;
         endcase
      end
      return rgb;
   endfunction

endpackage

// ===== rtl/asgr_front.sv =====
// ----------------------------------------------------------------------------
// asgr_front: escape sequence parser
// strips sgr sequences, tracks colour state and pushes kept characters
// ----------------------------------------------------------------------------
module asgr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [asgr_pkg::CP_W-1:0]   req_codepoint,
   input  logic                        req_end_of_string,
   input  asgr_pkg::asgr_qstat_type    qstat,
   output logic                        push,
   output asgr_pkg::asgr_entry_type    push_entry
);
   import asgr_pkg::*;

   typedef enum logic [2:0] {
      PH_TEXT = 3'b001,
      PH_ESC  = 3'b010,
      PH_SEQ  = 3'b100
   } asgr_phase_type;

   asgr_phase_type  phase_ff, phase_in;
   logic [7:0]      acc_ff, acc_in;
   logic            bold_ff, bold_in;
   logic [2:0]      pal_ff, pal_in;
   asgr_colour_type colour_ff, colour_in;

   logic            accept;
   logic            emit;
   logic            is_digit;
   logic            is_m;
   logic            is_semi;
   logic [11:0]     acc_prod;
   logic [7:0]      fg_off;
   // state after the code action of this character
   logic            act_bold;
   logic [2:0]      act_pal;
   asgr_colour_type act_colour;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign is_m      = (req_codepoint == CP_M);
   assign is_semi   = (req_codepoint == CP_SEMI);
   assign is_digit  = (req_codepoint >= CP_ZERO) && (req_codepoint <= CP_NINE);
   assign fg_off    = acc_ff - SGR_FG_FIRST;

   // 10 * code + digit, saturating at 255
   assign acc_prod = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                   + {8'd0, req_codepoint[3:0]};

   always_comb begin
      act_bold   = bold_ff;
      act_pal    = pal_ff;
      act_colour = colour_ff;
      if (acc_ff == SGR_RESET) begin
         act_bold   = 1'b0;
         act_pal    = PAL_IDX_RESET;
         act_colour = '{is_default: 1'b1, bold_table: 1'b0, index: PAL_IDX_RESET};
      end else if (acc_ff == SGR_BOLD) begin
         act_bold   = 1'b1;
         act_colour = '{is_default: 1'b0, bold_table: 1'b1, index: pal_ff};
      end else if (acc_ff == SGR_NOT_BOLD) begin
         act_bold   = 1'b0;
         act_colour = '{is_default: 1'b0, bold_table: 1'b0, index: pal_ff};
      end else if (acc_ff >= SGR_FG_FIRST && acc_ff <= SGR_FG_LAST) begin
         act_pal    = fg_off[2:0];
         act_colour = '{is_default: 1'b0, bold_table: bold_ff, index: fg_off[2:0]};
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      bold_in   = bold_ff;
      pal_in    = pal_ff;
      colour_in = colour_ff;
      emit      = 1'b0;
      unique case (phase_ff)
         PH_ESC: begin
            if (req_codepoint == CP_LBRACKET) begin
               phase_in = PH_SEQ;
               acc_in   = 8'd0;
               emit     = req_end_of_string;
            end else begin
               phase_in = PH_TEXT;
               emit     = 1'b1;
            end
         end
         PH_SEQ: begin
            if (is_m || is_semi) begin
               bold_in   = act_bold;
               pal_in    = act_pal;
               colour_in = act_colour;
               acc_in    = 8'd0;
            end
            if (is_m) begin
               phase_in = PH_TEXT;
            end else begin
               if (is_digit) begin
                  acc_in = (acc_prod > 12'd255) ? 8'hFF : acc_prod[7:0];
               end
               emit = req_end_of_string;
            end
         end
         default: begin
            phase_in = PH_TEXT;
            if (req_codepoint == CP_ESC) begin
               if (!req_end_of_string) begin
                  phase_in = PH_ESC;
               end
            end else begin
               emit = 1'b1;
            end
         end
      endcase
      if (req_end_of_string) begin
         phase_in  = PH_TEXT;
         acc_in    = 8'd0;
         bold_in   = 1'b0;
         pal_in    = PAL_IDX_RESET;
         colour_in = '{is_default: 1'b1, bold_table: 1'b0, index: PAL_IDX_RESET};
      end
   end

   // the character leaves with the colour in effect after its own code action
   assign push                 = accept && emit;
   assign push_entry.codepoint = req_codepoint;
   assign push_entry.colour    = (phase_ff == PH_SEQ && is_semi) ? act_colour : colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TEXT;
         acc_ff    <= 8'd0;
         bold_ff   <= 1'b0;
         pal_ff    <= PAL_IDX_RESET;
         colour_ff <= '{is_default: 1'b1, bold_table: 1'b0, index: PAL_IDX_RESET};
      end else if (accept) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         bold_ff   <= bold_in;
         pal_ff    <= pal_in;
         colour_ff <= colour_in;
      end
   end

   // end of string brings the parser back to plain text with a clear code
   a_eos_reset: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_string |=> phase_ff == PH_TEXT && acc_ff == 8'd0
         && colour_ff.is_default)
      else $error("parser state not cleared at end of string");

   // an sgr terminator is never shown
   a_m_hidden: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_SEQ && is_m |-> !push)
      else $error("sequence terminator pushed as a character");

endmodule

// ===== rtl/asgr_queue.sv =====
// ----------------------------------------------------------------------------
// asgr_queue: small character queue
// decouples the parser from the colour lookup and output stage
// ----------------------------------------------------------------------------
module asgr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  asgr_pkg::asgr_entry_type push_entry,
   input  logic                     pop,
   output asgr_pkg::asgr_entry_type head,
   output asgr_pkg::asgr_qstat_type qstat
);
   import asgr_pkg::*;

   asgr_entry_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // occupancy always matches the pointer distance
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

// ===== rtl/asgr_back.sv =====
// ----------------------------------------------------------------------------
// asgr_back: colour lookup and output register
// holds the default colour registers, resolves palette entries, drives rsp
// ----------------------------------------------------------------------------
module asgr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [asgr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asgr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  asgr_pkg::asgr_entry_type       head,
   input  asgr_pkg::asgr_qstat_type       qstat,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [asgr_pkg::CP_W-1:0]      rsp_char_out,
   output logic [asgr_pkg::RGB_W-1:0]     rsp_top_rgb,
   output logic [asgr_pkg::ALPHA_W-1:0]   rsp_top_alpha,
   output logic [asgr_pkg::RGB_W-1:0]     rsp_bottom_rgb,
   output logic [asgr_pkg::ALPHA_W-1:0]   rsp_bottom_alpha
);
   import asgr_pkg::*;

   logic [RGB_W-1:0]   top_rgb_cfg_ff;
   logic [ALPHA_W-1:0] top_alpha_cfg_ff;
   logic [RGB_W-1:0]   bottom_rgb_cfg_ff;
   logic [ALPHA_W-1:0] bottom_alpha_cfg_ff;

   logic               valid_ff;
   logic [CP_W-1:0]    char_ff;
   logic [RGB_W-1:0]   top_ff, top_in;
   logic [RGB_W-1:0]   bottom_ff, bottom_in;
   logic [ALPHA_W-1:0] top_alpha_ff;
   logic [ALPHA_W-1:0] bottom_alpha_ff;
   logic [RGB_W-1:0]   pal_rgb;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_rgb_cfg_ff      <= 24'hFFFFFF;
         top_alpha_cfg_ff    <= 8'hFF;
         bottom_rgb_cfg_ff   <= 24'hFFFFFF;
         bottom_alpha_cfg_ff <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOP_RGB:      top_rgb_cfg_ff      <= csr_wdata;
            CSR_TOP_ALPHA:    top_alpha_cfg_ff    <= csr_wdata[ALPHA_W-1:0];
            CSR_BOTTOM_RGB:   bottom_rgb_cfg_ff   <= csr_wdata;
            CSR_BOTTOM_ALPHA: bottom_alpha_cfg_ff <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   assign pal_rgb   = palette_rgb(head.colour.bold_table, head.colour.index);
   assign top_in    = head.colour.is_default ? top_rgb_cfg_ff : pal_rgb;
   assign bottom_in = head.colour.is_default ? bottom_rgb_cfg_ff : pal_rgb;

   // load the output register whenever it is empty or being drained
   assign pop = !qstat.empty && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) begin
         char_ff         <= head.codepoint;
         top_ff          <= top_in;
         bottom_ff       <= bottom_in;
         top_alpha_ff    <= top_alpha_cfg_ff;
         bottom_alpha_ff <= bottom_alpha_cfg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_char_out     = char_ff;
   assign rsp_top_rgb      = top_ff;
   assign rsp_top_alpha    = top_alpha_ff;
   assign rsp_bottom_rgb   = bottom_ff;
   assign rsp_bottom_alpha = bottom_alpha_ff;

   // a palette colour is shared by top and bottom
   a_pal_shared: assert property (@(posedge clock) disable iff (reset)
      pop && !head.colour.is_default |=> rsp_top_rgb == rsp_bottom_rgb)
      else $error("palette colour differs between top and bottom");

endmodule

// ===== rtl/ansi_sgr_colour_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_colour_parser: sgr escape stripper with per-character colour
// parser front end, four-entry character queue, colour lookup back end
// ----------------------------------------------------------------------------
// One codepoint is taken per clock on the req channel, with end_of_string
// marking the last codepoint of a string. SGR sequences (ESC '[' codes 'm')
// are removed; codes 0, 1, 22 and 30-37 change the colour, others are ignored.
// Every other character comes out on the rsp channel with its top and bottom
// colour and alpha, either the programmed defaults or an entry of the normal
// or bold palette. A kept character is written into the queue when its
// request is taken and is then loaded into the output register once that
// register is empty or being drained; sustained rate is one request per clock
// while the queue is not full. The four-entry queue absorbs rsp
// stalls: req_ready drops only when it is full. Configuration registers
// (0 top rgb, 1 top alpha, 2 bottom rgb, 3 bottom alpha) are written through
// csr_we and take effect at once; write them only while no character is in
// flight.
// ----------------------------------------------------------------------------
module ansi_sgr_colour_parser (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [asgr_pkg::CP_W-1:0]         req_codepoint,
   input  logic                              req_end_of_string,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [asgr_pkg::CP_W-1:0]         rsp_char_out,
   output logic [asgr_pkg::RGB_W-1:0]        rsp_top_rgb,
   output logic [asgr_pkg::ALPHA_W-1:0]      rsp_top_alpha,
   output logic [asgr_pkg::RGB_W-1:0]        rsp_bottom_rgb,
   output logic [asgr_pkg::ALPHA_W-1:0]      rsp_bottom_alpha,
   // configuration write port
   input  logic                              csr_we,
   input  logic [asgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import asgr_pkg::*;

   // front to queue
   logic           push;
   asgr_entry_type push_entry;
   // queue to back
   logic           pop;
   asgr_entry_type head;
   asgr_qstat_type qstat;

   // parser: one step per request, pushes only displayable characters
   asgr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_codepoint     (req_codepoint),
      .req_end_of_string (req_end_of_string),
      .qstat             (qstat),
      .push              (push),
      .push_entry        (push_entry)
   );

   // character queue between parser and output
   asgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // colour resolution and output register
   asgr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .head             (head),
      .qstat            (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_top_rgb      (rsp_top_rgb),
      .rsp_top_alpha    (rsp_top_alpha),
      .rsp_bottom_rgb   (rsp_bottom_rgb),
      .rsp_bottom_alpha (rsp_bottom_alpha)
   );

endmodule
